@@ rtl/breit_wigner_mass_sampler_macros.svh @@
// Assertion helpers for the mass sampler; clk and rst_n come from the using scope.
`ifndef BREIT_WIGNER_MASS_SAMPLER_MACROS_SVH
`define BREIT_WIGNER_MASS_SAMPLER_MACROS_SVH

// Same-cycle implication.
`define BWMS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BWMS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bwms_pkg.sv @@
package bwms_pkg;

    localparam int MASS_W         = 32;
    localparam int DRAW_W         = 32;
    localparam int CFG_IDX_W      = 8;
    localparam int ANG_W          = 34;
    localparam int WIDE_W         = 64;
    localparam int MASS_BITS_DEF  = 32;
    localparam int ANGLE_ITER_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MASS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES_WIDTH  = 8'd1;

    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [13:0] NARROW_RATIO = 14'd10000;

    localparam logic [31:0] ATAN_HEAD [10] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149
    };

    typedef enum logic [1:0] {
        ST_SAMPLED   = 2'd0,
        ST_NARROW    = 2'd1,
        ST_NEGATIVE  = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef struct packed {
        logic              unb;
        logic              narrow;
        logic [MASS_W-1:0] pk;
        logic [WIDE_W-1:0] peak2;
        logic [WIDE_W-1:0] mw;
    } hi_tag_t;

    typedef struct packed {
        logic              narrow;
        logic [MASS_W-1:0] pk;
        logic [WIDE_W-1:0] peak2;
        logic [WIDE_W-1:0] mw;
    } rot_tag_t;

    typedef struct packed {
        logic              narrow;
        logic [MASS_W-1:0] pk;
        logic [WIDE_W-1:0] peak2;
        logic              yneg;
        logic              inf;
    } div_tag_t;

    typedef struct packed {
        logic              narrow;
        logic [MASS_W-1:0] pk;
        status_t           status;
    } sqrt_tag_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
        logic signed [ANG_W-1:0] v;
        if (idx < 10)
            v = ANG_W'(ATAN_HEAD[idx[3:0]]);
        else if (idx < 30)
            v = ANG_W'((64'sd1 <<< (30 - idx)) - 64'sd1);
        else
            v = '0;
        return v;
    endfunction

endpackage

@@ rtl/bwms_if.sv @@
interface bwms_in_if;
    import bwms_pkg::*;
    logic              valid;
    logic              ready;
    logic [DRAW_W-1:0] uniform_draw;
    logic [MASS_W-1:0] lower_mass;
    logic [MASS_W-1:0] upper_mass;
    logic              unbounded;
    modport source (output valid, uniform_draw, lower_mass, upper_mass, unbounded,
                    input ready);
    modport sink   (input valid, uniform_draw, lower_mass, upper_mass, unbounded,
                    output ready);
endinterface

interface bwms_out_if;
    import bwms_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASS_W-1:0] sampled_mass;
    status_t           status;
    modport source (output valid, sampled_mass, status, input ready);
    modport sink   (input valid, sampled_mass, status, output ready);
endinterface

interface bwms_cfg_if;
    import bwms_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MASS_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bwms_cordic_vec.sv @@
module bwms_cordic_vec #(
    parameter int  ITER  = bwms_pkg::ANGLE_ITER_DEF,
    parameter type tag_t = logic
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [bwms_pkg::WIDE_W-1:0]        num,
    input  logic                               neg,
    input  logic [bwms_pkg::WIDE_W-1:0]        den,
    input  tag_t                               in_tag,
    output logic                               out_valid,
    output logic signed [bwms_pkg::ANG_W-1:0]  angle,
    output tag_t                               out_tag
);
    import bwms_pkg::*;

    logic [WIDE_W-1:0] m_in, xa, ya, ma, xb, yb, mb;
    logic [2:0]        rsh;

    logic              n0_v_reg, n1_v_reg;
    logic [WIDE_W-1:0] n0_x_reg, n0_y_reg, n0_m_reg;
    logic              n0_neg_reg, n1_neg_reg;
    tag_t              n0_tag_reg, n1_tag_reg;
    logic [WIDE_W-1:0] n1_x_next, n1_y_next;
    logic signed [WIDE_W-1:0] n1_x_reg, n1_y_reg;

    logic signed [WIDE_W-1:0] x_reg [ITER-1];
    logic signed [WIDE_W-1:0] y_reg [ITER-1];
    logic signed [ANG_W-1:0]  z_reg [ITER];
    logic                     neg_reg [ITER];
    tag_t                     tag_reg [ITER];
    logic [ITER-1:0]          v_reg;

    // bring the larger term below 2^59, then coarse left shifts
    always_comb
    begin
        m_in = (num > den) ? num : den;
        if (m_in[63])      rsh = 3'd5;
        else if (m_in[62]) rsh = 3'd4;
        else if (m_in[61]) rsh = 3'd3;
        else if (m_in[60]) rsh = 3'd2;
        else if (m_in[59]) rsh = 3'd1;
        else               rsh = 3'd0;
        xa = den >> rsh;
        ya = num >> rsh;
        ma = m_in >> rsh;
        if (ma < (64'd1 << 27))
        begin
            xa = xa << 32; ya = ya << 32; ma = ma << 32;
        end
        if (ma < (64'd1 << 43))
        begin
            xa = xa << 16; ya = ya << 16; ma = ma << 16;
        end
    end

    // fine left shifts into [2^58, 2^59)
    always_comb
    begin
        xb = n0_x_reg;
        yb = n0_y_reg;
        mb = n0_m_reg;
        if (mb < (64'd1 << 51))
        begin
            xb = xb << 8; yb = yb << 8; mb = mb << 8;
        end
        if (mb < (64'd1 << 55))
        begin
            xb = xb << 4; yb = yb << 4; mb = mb << 4;
        end
        if (mb < (64'd1 << 57))
        begin
            xb = xb << 2; yb = yb << 2; mb = mb << 2;
        end
        if (mb < (64'd1 << 58))
        begin
            xb = xb << 1; yb = yb << 1;
        end
        n1_x_next = xb;
        n1_y_next = yb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_v_reg <= 1'b0;
            n1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            n0_v_reg <= in_valid;
            n1_v_reg <= n0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_x_reg   <= xa;
            n0_y_reg   <= ya;
            n0_m_reg   <= ma;
            n0_neg_reg <= neg;
            n0_tag_reg <= in_tag;
            n1_x_reg   <= signed'(n1_x_next);
            n1_y_reg   <= signed'(n1_y_next);
            n1_neg_reg <= n0_neg_reg;
            n1_tag_reg <= n0_tag_reg;
        end
    end

    for (genvar i = 0; i < ITER; i++)
    begin : g_iter
        logic signed [WIDE_W-1:0] xi, yi;
        logic signed [ANG_W-1:0]  zi;
        logic                     ni, vi;
        tag_t                     ti;

        if (i == 0)
        begin : g_head
            assign xi = n1_x_reg;
            assign yi = n1_y_reg;
            assign zi = '0;
            assign ni = n1_neg_reg;
            assign vi = n1_v_reg;
            assign ti = n1_tag_reg;
        end
        else
        begin : g_body
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = neg_reg[i-1];
            assign vi = v_reg[i-1];
            assign ti = tag_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yi < 0)
                    z_reg[i] <= zi - atan_step(i);
                else
                    z_reg[i] <= zi + atan_step(i);
                neg_reg[i] <= ni;
                tag_reg[i] <= ti;
            end
        end

        if (i < ITER - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (yi < 0)
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                    end
                    else
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[ITER-1];
    assign angle     = neg_reg[ITER-1] ? -z_reg[ITER-1] : z_reg[ITER-1];
    assign out_tag   = tag_reg[ITER-1];

endmodule

@@ rtl/bwms_cordic_rot.sv @@
module bwms_cordic_rot #(
    parameter int  ITER  = bwms_pkg::ANGLE_ITER_DEF,
    parameter type tag_t = logic
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [bwms_pkg::ANG_W-1:0]  angle,
    input  tag_t                               in_tag,
    output logic                               out_valid,
    output logic signed [bwms_pkg::WIDE_W-1:0] x,
    output logic signed [bwms_pkg::WIDE_W-1:0] y,
    output tag_t                               out_tag
);
    import bwms_pkg::*;

    localparam logic signed [WIDE_W-1:0] X_START = 64'sd1 <<< 59;

    logic signed [WIDE_W-1:0] x_reg [ITER];
    logic signed [WIDE_W-1:0] y_reg [ITER];
    logic signed [ANG_W-1:0]  z_reg [ITER-1];
    tag_t                     tag_reg [ITER];
    logic [ITER-1:0]          v_reg;

    for (genvar i = 0; i < ITER; i++)
    begin : g_iter
        logic signed [WIDE_W-1:0] xi, yi;
        logic signed [ANG_W-1:0]  zi;
        logic                     vi;
        tag_t                     ti;

        if (i == 0)
        begin : g_head
            assign xi = X_START;
            assign yi = '0;
            assign zi = angle;
            assign vi = in_valid;
            assign ti = in_tag;
        end
        else
        begin : g_body
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign vi = v_reg[i-1];
            assign ti = tag_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zi >= 0)
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                end
                tag_reg[i] <= ti;
            end
        end

        if (i < ITER - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (zi >= 0)
                        z_reg[i] <= zi - atan_step(i);
                    else
                        z_reg[i] <= zi + atan_step(i);
                end
            end
        end
    end

    assign out_valid = v_reg[ITER-1];
    assign x         = x_reg[ITER-1];
    assign y         = y_reg[ITER-1];
    assign out_tag   = tag_reg[ITER-1];

endmodule

@@ rtl/bwms_div.sv @@
module bwms_div #(
    parameter type tag_t = logic
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [bwms_pkg::WIDE_W-1:0] hi,
    input  logic [bwms_pkg::WIDE_W-1:0] lo,
    input  logic [bwms_pkg::WIDE_W-1:0] d,
    input  tag_t                        in_tag,
    output logic                        out_valid,
    output logic [bwms_pkg::WIDE_W-1:0] q,
    output logic                        fail,
    output tag_t                        out_tag
);
    import bwms_pkg::*;

    localparam int STEPS = WIDE_W;

    // remainder stays below the divisor (< 2^62), so 64 bits hold the shifted value
    logic [WIDE_W-1:0] rem_reg  [STEPS-1];
    logic [WIDE_W-1:0] lq_reg   [STEPS];
    logic [WIDE_W-1:0] d_reg    [STEPS-1];
    logic              fail_reg [STEPS];
    tag_t              tag_reg  [STEPS];
    logic [STEPS-1:0]  v_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [WIDE_W-1:0] ri, li, di, rs, rn;
        logic              fi, vi, ge;
        tag_t              ti;

        if (k == 0)
        begin : g_head
            assign ri = hi;
            assign li = lo;
            assign di = d;
            assign fi = (hi >= d);
            assign vi = in_valid;
            assign ti = in_tag;
        end
        else
        begin : g_body
            assign ri = rem_reg[k-1];
            assign li = lq_reg[k-1];
            assign di = d_reg[k-1];
            assign fi = fail_reg[k-1];
            assign vi = v_reg[k-1];
            assign ti = tag_reg[k-1];
        end

        assign rs = {ri[WIDE_W-2:0], li[WIDE_W-1]};
        assign ge = (rs >= di);
        assign rn = ge ? (rs - di) : rs;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lq_reg[k]   <= {li[WIDE_W-2:0], ge};
                fail_reg[k] <= fi;
                tag_reg[k]  <= ti;
            end
        end

        if (k < STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rn;
                    d_reg[k]   <= di;
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign q         = lq_reg[STEPS-1];
    assign fail      = fail_reg[STEPS-1];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

@@ rtl/bwms_sqrt.sv @@
module bwms_sqrt #(
    parameter type tag_t = logic
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [bwms_pkg::WIDE_W-1:0] value,
    input  tag_t                        in_tag,
    output logic                        out_valid,
    output logic [bwms_pkg::MASS_W-1:0] root,
    output tag_t                        out_tag
);
    import bwms_pkg::*;

    localparam int STEPS = WIDE_W / 2;

    logic [WIDE_W-1:0] v_reg   [STEPS-1];
    logic [WIDE_W-1:0] r_reg   [STEPS];
    tag_t              tag_reg [STEPS];
    logic [STEPS-1:0]  vld_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [WIDE_W-1:0] BIT = 64'd1 << (WIDE_W - 2 - 2 * k);
        logic [WIDE_W-1:0] vi, ri, t;
        logic              vldi, ge;
        tag_t              ti;

        if (k == 0)
        begin : g_head
            assign vi   = value;
            assign ri   = '0;
            assign vldi = in_valid;
            assign ti   = in_tag;
        end
        else
        begin : g_body
            assign vi   = v_reg[k-1];
            assign ri   = r_reg[k-1];
            assign vldi = vld_reg[k-1];
            assign ti   = tag_reg[k-1];
        end

        assign t  = ri + BIT;
        assign ge = (vi >= t);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vldi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= ge ? ((ri >> 1) + BIT) : (ri >> 1);
                tag_reg[k] <= ti;
            end
        end

        if (k < STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                    v_reg[k] <= ge ? (vi - t) : vi;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign root      = r_reg[STEPS-1][MASS_W-1:0];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

@@ rtl/breit_wigner_mass_sampler.sv @@
// Relativistic Breit-Wigner mass sampler.
// cfg: write word of register index and data; index 0 is the pole mass, index 1
// the total width (both Q16.16 GeV, reset 0). Other indices are dropped. cfg is
// always ready; write only while no item is in flight.
// din: one word per draw - uniform value (32 fractional bits), lower and upper
// mass bounds and the unbounded flag. dout: sampled mass (Q16.16) and status.
// One word in, one word out, strictly in order.
// Throughput: one word per cycle while dout is not stalled. The pipeline depth
// comes from the two CORDIC chains (one iteration per stage), the 64-stage
// quotient pipeline for the tangent term and the 32-stage square root, plus ten
// stages of setup and output.
// A stalled dout freezes the whole pipeline in place; din.ready falls in the
// same cycle and nothing is dropped or repeated. The result register keeps
// its word until taken.
// Reset clears every valid bit and both registers; no clearing pass is needed.
`include "breit_wigner_mass_sampler_macros.svh"

module breit_wigner_mass_sampler #(
    parameter int MASS_BITS        = bwms_pkg::MASS_BITS_DEF,
    parameter int ANGLE_ITERATIONS = bwms_pkg::ANGLE_ITER_DEF
) (
    input logic        clk,
    input logic        rst_n,
    bwms_cfg_if.sink   cfg,
    bwms_in_if.sink    din,
    bwms_out_if.source dout
);
    import bwms_pkg::*;

    localparam int MASK_BITS = (MASS_BITS < MASS_W) ? MASS_BITS : MASS_W;
    localparam logic [MASS_W-1:0] MASS_MASK = MASS_W'((64'd1 << MASK_BITS) - 64'd1);

    logic adv;

    logic [MASS_W-1:0] peak_reg, width_reg;

    // stage A
    logic              va_reg;
    logic [DRAW_W-1:0] r_a_reg;
    logic [MASS_W-1:0] lo_a_reg, hi_a_reg, pk_a_reg, wd_a_reg;
    logic              unb_a_reg;

    // stage B
    logic              vb_reg;
    logic [WIDE_W-1:0] peak2_b_reg, mw_b_reg, lo2_b_reg, hi2_b_reg;
    logic [DRAW_W-1:0] r_b_reg;
    logic [MASS_W-1:0] pk_b_reg;
    logic              unb_b_reg, narrow_b_reg;
    logic              narrow_b_next;

    // stage C
    logic              vc_reg;
    logic [WIDE_W-1:0] numhi_c_reg, numlo_c_reg;
    logic              neghi_c_reg, neglo_c_reg;
    logic [DRAW_W-1:0] r_c_reg;
    hi_tag_t           htag_c_reg;

    // atan lanes
    logic                    vec_hi_v, vec_lo_v;
    logic signed [ANG_W-1:0] a_hi, a_lo;
    hi_tag_t                 htag_v;
    logic [DRAW_W-1:0]       r_v;

    // stage D
    logic                    vd_reg;
    logic [WIDE_W-1:0]       prod_d_reg;
    logic                    sgn_d_reg;
    logic signed [ANG_W-1:0] base_d_reg;
    rot_tag_t                rtag_d_reg;
    logic signed [ANG_W:0]   diff;
    logic [ANG_W:0]          diff_mag;
    logic [DRAW_W-1:0]       mag_u, mul_a, mul_b;
    logic                    neg_u;

    // stage E (feeds the rotation chain)
    logic [DRAW_W-1:0]       off_e;
    logic signed [ANG_W-1:0] angle_e;

    // rotation outputs
    logic                     rot_v;
    logic signed [WIDE_W-1:0] rot_x, rot_y;
    rot_tag_t                 rtag_r;
    logic [WIDE_W-1:0]        ym;

    // stage F
    logic              vf_reg;
    logic [WIDE_W-1:0] ll_f_reg, lh_f_reg, hl_f_reg, hh_f_reg, x_f_reg;
    div_tag_t          dtag_f_reg;

    // stage G
    logic              vg_reg;
    logic [WIDE_W-1:0] qh_g_reg, ql_g_reg, d_g_reg;
    div_tag_t          dtag_g_reg;
    logic [2*WIDE_W-1:0] prod_g;

    // divider outputs
    logic              div_v, div_fail;
    logic [WIDE_W-1:0] div_q;
    div_tag_t          dtag_q;

    // stage H
    logic              vh_reg;
    logic [WIDE_W-1:0] s_h_reg, s_h_next;
    sqrt_tag_t         stag_h_reg, stag_h_next;
    logic [WIDE_W:0]   sum65;
    logic              inf_h;

    // root outputs
    logic              sq_v;
    logic [MASS_W-1:0] sq_root;
    sqrt_tag_t         stag_s;

    // output register
    logic              dv_reg;
    logic [MASS_W-1:0] dmass_reg, dmass_next;
    status_t           dst_reg, dst_next;

    assign adv       = !dv_reg || dout.ready;
    assign din.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            width_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_PEAK_MASS)
                peak_reg <= cfg.data;
            else if (cfg.index == REG_RES_WIDTH)
                width_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            dv_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= din.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vec_hi_v && vec_lo_v;
            vf_reg <= rot_v;
            vg_reg <= vf_reg;
            vh_reg <= div_v;
            dv_reg <= sq_v;
        end
    end

    assign narrow_b_next = (pk_a_reg == '0) ||
                           ((46'(wd_a_reg) * 46'(NARROW_RATIO)) < 46'(pk_a_reg));

    // angle interpolation: one 32x32 product shared by both modes
    always_comb
    begin
        diff     = (ANG_W+1)'(a_lo) - (ANG_W+1)'(a_hi);
        diff_mag = (diff < 0) ? (ANG_W+1)'(-diff) : (ANG_W+1)'(diff);
        neg_u    = !r_v[DRAW_W-1];
        mag_u    = neg_u ? ((DRAW_W)'(1) << (DRAW_W-1)) - r_v
                         : r_v - ((DRAW_W)'(1) << (DRAW_W-1));
        mul_a    = htag_v.unb ? mag_u : diff_mag[DRAW_W-1:0];
        mul_b    = htag_v.unb ? PI_Q30 : r_v;
    end

    assign off_e   = prod_d_reg[WIDE_W-1:DRAW_W];
    assign angle_e = sgn_d_reg ? base_d_reg - signed'(ANG_W'(off_e))
                               : base_d_reg + signed'(ANG_W'(off_e));

    assign ym     = (rot_y < 0) ? WIDE_W'(-rot_y) : WIDE_W'(rot_y);
    assign prod_g = {hh_f_reg, 64'd0} + {32'd0, lh_f_reg, 32'd0} +
                    {32'd0, hl_f_reg, 32'd0} + {64'd0, ll_f_reg};

    always_comb
    begin
        inf_h               = dtag_q.inf || div_fail;
        sum65               = {1'b0, dtag_q.peak2} + {1'b0, div_q};
        stag_h_next.narrow  = dtag_q.narrow;
        stag_h_next.pk      = dtag_q.pk;
        if (!dtag_q.yneg)
        begin
            if (inf_h || sum65[WIDE_W])
            begin
                s_h_next           = '1;
                stag_h_next.status = ST_SATURATED;
            end
            else
            begin
                s_h_next           = sum65[WIDE_W-1:0];
                stag_h_next.status = ST_SAMPLED;
            end
        end
        else
        begin
            if (inf_h || (div_q > dtag_q.peak2))
            begin
                s_h_next           = '0;
                stag_h_next.status = ST_NEGATIVE;
            end
            else
            begin
                s_h_next           = dtag_q.peak2 - div_q;
                stag_h_next.status = ST_SAMPLED;
            end
        end
    end

    always_comb
    begin
        if (stag_s.narrow)
        begin
            dmass_next = stag_s.pk;
            dst_next   = ST_NARROW;
        end
        else if (stag_s.status == ST_NEGATIVE)
        begin
            dmass_next = '0;
            dst_next   = ST_NEGATIVE;
        end
        else if (sq_root > MASS_MASK)
        begin
            dmass_next = MASS_MASK;
            dst_next   = ST_SATURATED;
        end
        else
        begin
            dmass_next = sq_root;
            dst_next   = stag_s.status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_a_reg   <= din.uniform_draw;
            lo_a_reg  <= din.lower_mass & MASS_MASK;
            hi_a_reg  <= din.upper_mass & MASS_MASK;
            unb_a_reg <= din.unbounded;
            pk_a_reg  <= peak_reg & MASS_MASK;
            wd_a_reg  <= width_reg & MASS_MASK;

            peak2_b_reg  <= pk_a_reg * pk_a_reg;
            mw_b_reg     <= pk_a_reg * wd_a_reg;
            lo2_b_reg    <= lo_a_reg * lo_a_reg;
            hi2_b_reg    <= hi_a_reg * hi_a_reg;
            r_b_reg      <= r_a_reg;
            pk_b_reg     <= pk_a_reg;
            unb_b_reg    <= unb_a_reg;
            narrow_b_reg <= narrow_b_next;

            neghi_c_reg <= hi2_b_reg < peak2_b_reg;
            numhi_c_reg <= (hi2_b_reg < peak2_b_reg) ? peak2_b_reg - hi2_b_reg
                                                     : hi2_b_reg - peak2_b_reg;
            neglo_c_reg <= lo2_b_reg < peak2_b_reg;
            numlo_c_reg <= (lo2_b_reg < peak2_b_reg) ? peak2_b_reg - lo2_b_reg
                                                     : lo2_b_reg - peak2_b_reg;
            r_c_reg           <= r_b_reg;
            htag_c_reg.unb    <= unb_b_reg;
            htag_c_reg.narrow <= narrow_b_reg;
            htag_c_reg.pk     <= pk_b_reg;
            htag_c_reg.peak2  <= peak2_b_reg;
            htag_c_reg.mw     <= mw_b_reg;

            prod_d_reg        <= mul_a * mul_b;
            sgn_d_reg         <= htag_v.unb ? neg_u : (diff < 0);
            base_d_reg        <= htag_v.unb ? '0 : a_hi;
            rtag_d_reg.narrow <= htag_v.narrow;
            rtag_d_reg.pk     <= htag_v.pk;
            rtag_d_reg.peak2  <= htag_v.peak2;
            rtag_d_reg.mw     <= htag_v.mw;

            ll_f_reg          <= rtag_r.mw[31:0]  * ym[31:0];
            lh_f_reg          <= rtag_r.mw[31:0]  * ym[63:32];
            hl_f_reg          <= rtag_r.mw[63:32] * ym[31:0];
            hh_f_reg          <= rtag_r.mw[63:32] * ym[63:32];
            x_f_reg           <= WIDE_W'(rot_x);
            dtag_f_reg.narrow <= rtag_r.narrow;
            dtag_f_reg.pk     <= rtag_r.pk;
            dtag_f_reg.peak2  <= rtag_r.peak2;
            dtag_f_reg.yneg   <= rot_y < 0;
            dtag_f_reg.inf    <= rot_x <= 0;

            qh_g_reg   <= prod_g[2*WIDE_W-1:WIDE_W];
            ql_g_reg   <= prod_g[WIDE_W-1:0];
            d_g_reg    <= x_f_reg;
            dtag_g_reg <= dtag_f_reg;

            s_h_reg    <= s_h_next;
            stag_h_reg <= stag_h_next;

            dmass_reg <= dmass_next;
            dst_reg   <= dst_next;
        end
    end

    bwms_cordic_vec #(
        .ITER  (ANGLE_ITERATIONS),
        .tag_t (hi_tag_t)
    ) u_vec_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vc_reg),
        .num       (numhi_c_reg),
        .neg       (neghi_c_reg),
        .den       (htag_c_reg.mw),
        .in_tag    (htag_c_reg),
        .out_valid (vec_hi_v),
        .angle     (a_hi),
        .out_tag   (htag_v)
    );

    bwms_cordic_vec #(
        .ITER  (ANGLE_ITERATIONS),
        .tag_t (logic [DRAW_W-1:0])
    ) u_vec_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vc_reg),
        .num       (numlo_c_reg),
        .neg       (neglo_c_reg),
        .den       (htag_c_reg.mw),
        .in_tag    (r_c_reg),
        .out_valid (vec_lo_v),
        .angle     (a_lo),
        .out_tag   (r_v)
    );

    bwms_cordic_rot #(
        .ITER  (ANGLE_ITERATIONS),
        .tag_t (rot_tag_t)
    ) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vd_reg),
        .angle     (angle_e),
        .in_tag    (rtag_d_reg),
        .out_valid (rot_v),
        .x         (rot_x),
        .y         (rot_y),
        .out_tag   (rtag_r)
    );

    bwms_div #(
        .tag_t (div_tag_t)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vg_reg),
        .hi        (qh_g_reg),
        .lo        (ql_g_reg),
        .d         (d_g_reg),
        .in_tag    (dtag_g_reg),
        .out_valid (div_v),
        .q         (div_q),
        .fail      (div_fail),
        .out_tag   (dtag_q)
    );

    bwms_sqrt #(
        .tag_t (sqrt_tag_t)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vh_reg),
        .value     (s_h_reg),
        .in_tag    (stag_h_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_tag   (stag_s)
    );

    assign dout.valid        = dv_reg;
    assign dout.sampled_mass = dmass_reg;
    assign dout.status       = dst_reg;

    `BWMS_ASSERT_IMP(a_neg_zero, dv_reg && dst_reg == ST_NEGATIVE, dmass_reg == '0, "negative s word carries nonzero mass")
    `BWMS_ASSERT_IMP(a_sat_ones, dv_reg && dst_reg == ST_SATURATED, dmass_reg == MASS_MASK, "saturated word is not all ones")
    `BWMS_ASSERT_NXT(a_accept_enters, din.valid && din.ready, va_reg, "accepted word did not enter the pipeline")

endmodule
